// File: hdl/rbbr_pkg.sv
package rbbr_pkg;

  // ring geometry
  localparam int DEPTH  = 1024;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = AW + 1;
  localparam int DATA_W = 32;
  localparam int KIND_W = 2;

  // release window after reset: 80 percent of the ring
  localparam int RELEASE_RESET = DEPTH * 80 / 100;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [0:0] REG_RELEASE = 1'b0;

  localparam logic [CW-1:0] DEPTH_CW = CW'(DEPTH);

  typedef enum logic [KIND_W-1:0] {
    OP_INSERT = 2'd0,
    OP_FLUSH  = 2'd1,
    OP_PEEK   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_REL,
    ST_COMMIT
  } bst_t;

  // classified item waiting for the back end
  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] value;
    logic [AW-1:0]            index;
  } qent_t;

  // back end to front end control
  typedef struct packed {
    logic pop;
    logic init_busy;
  } bctl_t;

  typedef struct packed {
    logic [CW-1:0]            free_count;
    logic [CW-1:0]            used_total;
    logic [AW-1:0]            oldest_slot;
    logic [AW-1:0]            end_slot;
    logic [CW-1:0]            released;
    logic signed [DATA_W-1:0] entry_data;
    logic                     entry_valid;
  } res_t;

endpackage

// File: hdl/rbbr_in_if.sv
interface rbbr_in_if import rbbr_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;
  logic [AW-1:0]            index;

  modport source (output valid, kind, value, index, input ready);
  modport sink   (input valid, kind, value, index, output ready);
endinterface

// File: hdl/rbbr_out_if.sv
interface rbbr_out_if import rbbr_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CW-1:0]            free_count;
  logic [CW-1:0]            used_total;
  logic [AW-1:0]            oldest_slot;
  logic [AW-1:0]            end_slot;
  logic [CW-1:0]            released;
  logic signed [DATA_W-1:0] entry_data;
  logic                     entry_valid;

  modport source (output valid, free_count, used_total, oldest_slot, end_slot, released,
                  entry_data, entry_valid, input ready);
  modport sink   (input valid, free_count, used_total, oldest_slot, end_slot, released,
                  entry_data, entry_valid, output ready);
endinterface

// File: hdl/rbbr_ram.sv
module rbbr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port, registered read port returning the old word on a collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/rbbr_front.sv
module rbbr_front import rbbr_pkg::*; #(
  parameter int QDEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  rbbr_in_if.sink    in_ch,
  input  bctl_t      bctl,
  output qent_t      head,
  output logic       head_valid
);

  localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  qent_t          q_r [QDEPTH];
  logic [QPW-1:0] rd_ptr_r;
  logic [QPW-1:0] wr_ptr_r;
  logic [QCW-1:0] count_r;
  qent_t          ent;
  op_t            op;
  logic           push;

  // classify the incoming item and keep only the fields its kind uses
  always_comb begin
    unique case (in_ch.kind)
      2'd0:    op = OP_INSERT;
      2'd1:    op = OP_FLUSH;
      2'd2:    op = OP_PEEK;
      default: op = OP_NOP;
    endcase
    ent.op    = op;
    ent.value = (op == OP_INSERT) ? in_ch.value : '0;
    ent.index = (op == OP_PEEK) ? in_ch.index : '0;
  end

  assign in_ch.ready = (count_r != QCW'(QDEPTH)) && !bctl.init_busy;
  assign push        = in_ch.valid && in_ch.ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= ent;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPW'(1);
      end
      if (bctl.pop) begin
        rd_ptr_r <= (rd_ptr_r == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPW'(1);
      end
      if (push && !bctl.pop) begin
        count_r <= count_r + QCW'(1);
      end else if (!push && bctl.pop) begin
        count_r <= count_r - QCW'(1);
      end
    end
  end

  assign head       = q_r[rd_ptr_r];
  assign head_valid = (count_r != '0);

endmodule

// File: hdl/rbbr_back.sv
module rbbr_back import rbbr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [CW-1:0] release_count,
  input  qent_t         head,
  input  logic          head_valid,
  output bctl_t         bctl,
  rbbr_out_if.source    out_ch
);

  bst_t                     state_r, state_nxt;
  op_t                      op_r;
  logic signed [DATA_W-1:0] value_r;
  logic [AW-1:0]            wp_r;
  logic [AW-1:0]            oldest_r;
  logic [CW-1:0]            used_r;
  logic [CW-1:0]            rel_r;
  logic [CW-1:0]            cnt_r;
  logic [CW-1:0]            win_r;
  logic                     rdp_r;
  logic                     pend_r;
  logic                     out_valid_r;
  res_t                     res_r;
  res_t                     res_now;

  logic                     can_emit, emit, pop;
  logic                     need_rel, rel_go, commit, clear_end, rel_more;
  logic [AW-1:0]            walk_addr;

  logic                     v_we, v_wd, v_re, v_rd;
  logic [AW-1:0]            v_wa, v_ra;
  logic                     d_we, d_re;
  logic [AW-1:0]            d_ra;
  logic [DATA_W-1:0]        d_rd;

  rbbr_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_valid_ram (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd),
    .re(v_re), .raddr(v_ra), .rdata(v_rd)
  );

  rbbr_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_data_ram (
    .clk(clk), .we(d_we), .waddr(wp_r), .wdata(value_r),
    .re(d_re), .raddr(d_ra), .rdata(d_rd)
  );

  // status terms
  assign can_emit  = !out_valid_r || out_ch.ready;
  assign emit      = (state_r == ST_IDLE) && pend_r && can_emit;
  assign pop       = (state_r == ST_IDLE) && head_valid && (!pend_r || can_emit);
  assign need_rel  = (used_r >= DEPTH_CW) || v_rd;
  assign rel_go    = (state_r == ST_LOOK) && (op_r == OP_INSERT) && need_rel && (win_r != '0);
  assign commit    = ((state_r == ST_LOOK) && (op_r == OP_INSERT) && !rel_go) ||
                     (state_r == ST_COMMIT);
  assign clear_end = (cnt_r[AW-1:0] == AW'(DEPTH - 1));
  assign rel_more  = (cnt_r != win_r);
  assign walk_addr = wp_r + cnt_r[AW-1:0];

  assign bctl.pop       = pop;
  assign bctl.init_busy = (state_r == ST_CLEAR) && (op_r != OP_FLUSH);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clear_end) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (pop) begin
          unique case (head.op)
            OP_INSERT, OP_PEEK: state_nxt = ST_LOOK;
            OP_FLUSH:           state_nxt = ST_CLEAR;
            default:            state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOOK: begin
        state_nxt = rel_go ? ST_REL : ST_IDLE;
      end
      ST_REL: begin
        if (!rel_more) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    v_we = 1'b0;
    v_wa = wp_r;
    v_wd = 1'b0;
    v_re = 1'b0;
    v_ra = wp_r;
    d_we = 1'b0;
    d_re = 1'b0;
    d_ra = head.index;
    unique case (state_r)
      ST_CLEAR: begin
        v_we = 1'b1;
        v_wa = cnt_r[AW-1:0];
      end
      ST_IDLE: begin
        if (pop && (head.op == OP_INSERT)) begin
          v_re = 1'b1;
        end else if (pop && (head.op == OP_PEEK)) begin
          v_re = 1'b1;
          v_ra = head.index;
          d_re = 1'b1;
        end
      end
      ST_REL: begin
        if (rel_more) begin
          v_re = 1'b1;
          v_ra = walk_addr;
          v_we = 1'b1;
          v_wa = walk_addr;
        end
      end
      default: begin
      end
    endcase
    if (commit) begin
      v_we = 1'b1;
      v_wa = wp_r;
      v_wd = 1'b1;
      d_we = 1'b1;
    end
  end

  // status of the finished item
  always_comb begin
    res_now.free_count  = DEPTH_CW - used_r;
    res_now.used_total  = used_r;
    res_now.oldest_slot = oldest_r;
    res_now.end_slot    = wp_r;
    res_now.released    = rel_r;
    res_now.entry_data  = (op_r == OP_PEEK) ? d_rd : '0;
    res_now.entry_valid = (op_r == OP_PEEK) ? v_rd : 1'b0;
  end

  // payload of the current item
  always_ff @(posedge clk) begin
    if (pop) begin
      value_r <= head.value;
      win_r   <= (release_count > DEPTH_CW) ? DEPTH_CW : release_count;
    end
    if (emit) begin
      res_r <= res_now;
    end
  end

  // control and ring state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      op_r        <= OP_NOP;
      cnt_r       <= '0;
      wp_r        <= '0;
      oldest_r    <= '0;
      used_r      <= '0;
      rel_r       <= '0;
      rdp_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // hold the result until taken
      if (emit) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      // start a new item
      if (pop) begin
        op_r  <= head.op;
        rel_r <= '0;
        cnt_r <= '0;
        rdp_r <= 1'b0;
        if (head.op == OP_NOP) pend_r <= 1'b1;
      end

      // sweep the valid marks
      if (state_r == ST_CLEAR) begin
        cnt_r <= cnt_r + CW'(1);
        if (clear_end && (op_r == OP_FLUSH)) begin
          used_r   <= '0;
          oldest_r <= '0;
          wp_r     <= '0;
          pend_r   <= 1'b1;
        end
      end

      // classify the looked-up slot
      if (state_r == ST_LOOK) begin
        if (!rel_go) pend_r <= 1'b1;
        if ((op_r == OP_INSERT) && need_rel && (win_r == '0)) oldest_r <= wp_r;
      end

      // walk the release window, counting marks that were set
      if (state_r == ST_REL) begin
        if (rdp_r && v_rd) begin
          rel_r <= rel_r + CW'(1);
          if (used_r != '0) used_r <= used_r - CW'(1);
        end
        if (rel_more) begin
          cnt_r <= cnt_r + CW'(1);
          rdp_r <= 1'b1;
        end else begin
          rdp_r    <= 1'b0;
          oldest_r <= wp_r + win_r[AW-1:0];
        end
      end

      // store the word and advance the write pointer
      if (commit) begin
        wp_r <= wp_r + AW'(1);
        if (((state_r == ST_COMMIT) || !v_rd) && (used_r < DEPTH_CW)) begin
          used_r <= used_r + CW'(1);
        end
        if (state_r == ST_COMMIT) pend_r <= 1'b1;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.free_count  = res_r.free_count;
  assign out_ch.used_total  = res_r.used_total;
  assign out_ch.oldest_slot = res_r.oldest_slot;
  assign out_ch.end_slot    = res_r.end_slot;
  assign out_ch.released    = res_r.released;
  assign out_ch.entry_data  = res_r.entry_data;
  assign out_ch.entry_valid = res_r.entry_valid;

endmodule

// File: hdl/ring_buffer_bulk_release.sv
// An accepted item waits in the front-end queue until the back end pops it; insert and
// peek items then look up their slot, and each result is registered at the result port.
// Idle items go straight to their result. An insert that overflows also walks a release
// window of min(release_count, 1024) valid marks, one slot a cycle. A flush sweeps all
// 1024 valid marks, one a cycle, before its result. Reset (rst_n low, synchronous) runs
// the same sweep with in_ch.ready low; configuration writes are taken throughout.
module ring_buffer_bulk_release import rbbr_pkg::*; #(
  parameter int QDEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  rbbr_in_if.sink           in_ch,
  rbbr_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [CW-1:0] release_count_r;
  qent_t         head;
  logic          head_valid;
  bctl_t         bctl;
  logic          cfg_sel_rel;

  assign cfg_sel_rel = (cfg_paddr[CFG_AW-1] == REG_RELEASE);
  assign cfg_pready  = 1'b1;
  assign cfg_prdata  = cfg_sel_rel ? CFG_DW'(release_count_r) : '0;

  // release window register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      release_count_r <= CW'(RELEASE_RESET);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_rel) begin
      release_count_r <= cfg_pwdata[CW-1:0];
    end
  end

  rbbr_front #(.QDEPTH(QDEPTH)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .bctl(bctl),
    .head(head), .head_valid(head_valid)
  );

  rbbr_back u_back (
    .clk(clk), .rst_n(rst_n), .release_count(release_count_r),
    .head(head), .head_valid(head_valid), .bctl(bctl), .out_ch(out_ch)
  );

  // free and used always add up to the ring size
  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((12'(out_ch.free_count) + 12'(out_ch.used_total)) == 12'(DEPTH)))
    else $error("free and used counts do not sum to depth");

  // back end pops only a queued item
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    bctl.pop |-> head_valid)
    else $error("pop from empty queue");

  // in_ch.ready is low as the post-reset sweep starts
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_ch.ready)
    else $error("item accepted during reset sweep");

endmodule
